@@ rtl/core/apct_pkg.sv @@
`timescale 1ns / 1ps
package apct_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int IDX_W     = $clog2(NUM_SLOTS);
  localparam int SLOT_W    = 3;
  localparam int KIND_W    = 3;
  localparam int MASK_W    = 64;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_SCAN   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    RK_ADDED   = 3'd0,
    RK_FULL    = 3'd1,
    RK_REMOVED = 3'd2,
    RK_NOTICE  = 3'd3,
    RK_DONE    = 3'd4,
    RK_CLEARED = 3'd5
  } reply_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_SCAN_DONE
  } state_t;

  typedef struct packed {
    logic             do_add;
    logic             do_remove;
    logic             do_clear;
    logic             rd_en;
    logic             rd_valid;
    logic [IDX_W-1:0] rd_i;
    logic [IDX_W-1:0] rd_k;
    logic             emit;
    reply_t           kind;
    logic             swap;
    logic             last;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic hit_ik;
    logic hit_ki;
  } dp_stat_t;

endpackage

@@ rtl/core/apct_ctrl.sv @@
`timescale 1ns / 1ps
module apct_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         req_type,
  input  apct_pkg::dp_stat_t stat,
  output apct_pkg::dp_cmd_t  cmd,
  output logic               busy
);
  import apct_pkg::*;

  state_t           state, state_next;
  logic [IDX_W-1:0] pi, pi_next;
  logic [IDX_W-1:0] pk, pk_next;
  logic             second, second_next;
  logic             hold;
  logic             last_pair;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      pi     <= '0;
      pk     <= '0;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      pi     <= pi_next;
      pk     <= pk_next;
      second <= second_next;
    end
  end

  assign busy = (state != ST_IDLE);

  // both notices of one pair pending: hold the read stage
  assign hold      = stat.hit_ik & stat.hit_ki & ~second;
  assign last_pair = (pi == IDX_W'(NUM_SLOTS - 2)) && (pk == IDX_W'(NUM_SLOTS - 1));

  always_comb begin
    state_next  = state;
    pi_next     = pi;
    pk_next     = pk;
    second_next = second;
    cmd         = '0;
    cmd.kind    = RK_ADDED;
    cmd.rd_en   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (req_t'(req_type))
            REQ_ADD: begin
              cmd.emit = 1'b1;
              cmd.last = 1'b1;
              if (stat.full) begin
                cmd.kind = RK_FULL;
              end else begin
                cmd.do_add = 1'b1;
                cmd.kind   = RK_ADDED;
              end
            end
            REQ_REMOVE: begin
              cmd.do_remove = 1'b1;
              cmd.emit      = 1'b1;
              cmd.last      = 1'b1;
              cmd.kind      = RK_REMOVED;
            end
            REQ_SCAN: begin
              state_next  = ST_SCAN;
              pi_next     = '0;
              pk_next     = IDX_W'(1);
              second_next = 1'b0;
            end
            REQ_CLEAR: begin
              cmd.do_clear = 1'b1;
              cmd.emit     = 1'b1;
              cmd.last     = 1'b1;
              cmd.kind     = RK_CLEARED;
            end
          endcase
        end
      end
      ST_SCAN, ST_SCAN_LAST: begin
        cmd.kind = RK_NOTICE;
        if (second) begin
          cmd.emit    = 1'b1;
          cmd.swap    = 1'b1;
          second_next = 1'b0;
        end else if (stat.hit_ik) begin
          cmd.emit    = 1'b1;
          second_next = stat.hit_ki;
        end else if (stat.hit_ki) begin
          cmd.emit = 1'b1;
          cmd.swap = 1'b1;
        end
        cmd.rd_en = ~hold;
        if (state == ST_SCAN) begin
          cmd.rd_valid = 1'b1;
          cmd.rd_i     = pi;
          cmd.rd_k     = pk;
          if (!hold) begin
            if (last_pair) begin
              state_next = ST_SCAN_LAST;
            end else if (pk == IDX_W'(NUM_SLOTS - 1)) begin
              pi_next = pi + IDX_W'(1);
              pk_next = pi + IDX_W'(2);
            end else begin
              pk_next = pk + IDX_W'(1);
            end
          end
        end else if (!hold) begin
          state_next = ST_SCAN_DONE;
        end
      end
      ST_SCAN_DONE: begin
        cmd.emit   = 1'b1;
        cmd.last   = 1'b1;
        cmd.kind   = RK_DONE;
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/apct_dpath.sv @@
`timescale 1ns / 1ps
module apct_dpath (
  input  logic                      clk,
  input  logic                      rst,
  input  apct_pkg::dp_cmd_t         cmd,
  output apct_pkg::dp_stat_t        stat,
  input  logic [2:0]                slot_sel,
  input  logic signed [15:0]        box_x,
  input  logic signed [15:0]        box_y,
  input  logic [14:0]               box_w,
  input  logic [14:0]               box_h,
  input  logic [2:0]                box_kind,
  input  logic                      wants_notify,
  input  logic                      cfg_we,
  input  logic [apct_pkg::MASK_W-1:0] cfg_wdata,
  output logic                      reply_valid,
  output logic [2:0]                reply_kind,
  output logic [2:0]                owner_slot,
  output logic [2:0]                other_slot,
  output logic                      last
);
  import apct_pkg::*;

  typedef struct packed {
    logic [14:0]        h;
    logic [14:0]        w;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } box_t;

  function automatic logic boxes_overlap(box_t a, box_t b);
    logic signed [16:0] ax, ay, bx, by, ax_end, ay_end, bx_end, by_end;
    ax     = {a.x[15], a.x};
    ay     = {a.y[15], a.y};
    bx     = {b.x[15], b.x};
    by     = {b.y[15], b.y};
    ax_end = ax + $signed({2'b00, a.w});
    ay_end = ay + $signed({2'b00, a.h});
    bx_end = bx + $signed({2'b00, b.w});
    by_end = by + $signed({2'b00, b.h});
    return (ax < bx_end) && (ax_end > bx) && (ay < by_end) && (ay_end > by);
  endfunction

  box_t                slot_box    [NUM_SLOTS];
  logic [KIND_W-1:0]   slot_kind   [NUM_SLOTS];
  logic                slot_notify [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] slot_used;
  logic [MASK_W-1:0]   notify_mask;

  logic [IDX_W-1:0]    free_idx;
  logic                sel_ok;

  box_t                box_a, box_b;
  logic [KIND_W-1:0]   kind_a, kind_b;
  logic                ntf_a, ntf_b;
  logic [IDX_W-1:0]    ev_i, ev_k;
  logic                ev_valid;
  logic                ovl;

  logic [SLOT_W-1:0]   owner_d, other_d;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (!slot_used[s]) free_idx = IDX_W'(s);
    end
  end

  assign sel_ok    = ({1'b0, slot_sel} < 4'(NUM_SLOTS));
  assign stat.full = &slot_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used   <= '0;
      notify_mask <= '0;
    end else begin
      if (cfg_we) notify_mask <= cfg_wdata;
      if (cmd.do_clear) begin
        slot_used <= '0;
      end else if (cmd.do_add) begin
        slot_used[free_idx] <= 1'b1;
      end else if (cmd.do_remove && sel_ok) begin
        slot_used[slot_sel[IDX_W-1:0]] <= 1'b0;
      end
    end
  end

  // slot table: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.do_add) begin
      slot_box[free_idx]    <= '{h: box_h, w: box_w, y: box_y, x: box_x};
      slot_kind[free_idx]   <= box_kind;
      slot_notify[free_idx] <= wants_notify;
    end
    if (cmd.rd_en) begin
      box_a  <= slot_box[cmd.rd_i];
      box_b  <= slot_box[cmd.rd_k];
      kind_a <= slot_kind[cmd.rd_i];
      kind_b <= slot_kind[cmd.rd_k];
      ntf_a  <= slot_notify[cmd.rd_i];
      ntf_b  <= slot_notify[cmd.rd_k];
      ev_i   <= cmd.rd_i;
      ev_k   <= cmd.rd_k;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (cmd.rd_en) begin
      ev_valid <= cmd.rd_valid & slot_used[cmd.rd_i] & slot_used[cmd.rd_k];
    end
  end

  assign ovl         = boxes_overlap(box_a, box_b);
  assign stat.hit_ik = ev_valid & ovl & ntf_a & notify_mask[{kind_a, kind_b}];
  assign stat.hit_ki = ev_valid & ovl & ntf_b & notify_mask[{kind_b, kind_a}];

  always_comb begin
    owner_d = '0;
    other_d = '0;
    unique case (cmd.kind)
      RK_ADDED:   owner_d = SLOT_W'(free_idx);
      RK_REMOVED: owner_d = slot_sel;
      RK_NOTICE: begin
        owner_d = cmd.swap ? SLOT_W'(ev_k) : SLOT_W'(ev_i);
        other_d = cmd.swap ? SLOT_W'(ev_i) : SLOT_W'(ev_k);
      end
      RK_FULL, RK_DONE, RK_CLEARED: begin
        owner_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_valid <= 1'b0;
    end else begin
      reply_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    reply_kind <= cmd.kind;
    owner_slot <= owner_d;
    other_slot <= other_d;
    last       <= cmd.last;
  end

endmodule

@@ rtl/core/aabb_pair_collision_table_top.sv @@
`timescale 1ns / 1ps
// channel   ports                                               handshake
// request   req_type slot_sel box_x box_y box_w box_h            start & !busy
//           box_kind wants_notify
// reply     reply_kind owner_slot other_slot last                reply_valid, one cycle
// config    cfg_wdata (notify_mask)                              cfg_we
//
// add, remove and clear are done while idle; the reply shows the next cycle and busy stays low.
// a scan walks all slot pairs through the table's two read ports, one pair a cycle, except that
// a pair that notifies both ways holds the read stage while its second notice is sent.
// rst is synchronous: table empty, notify_mask zero, no reply pending.
// the reply side cannot stall; every reply is shown for exactly one cycle.
module aabb_pair_collision_table_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  req_type,
  input  logic [2:0]                  slot_sel,
  input  logic signed [15:0]          box_x,
  input  logic signed [15:0]          box_y,
  input  logic [14:0]                 box_w,
  input  logic [14:0]                 box_h,
  input  logic [2:0]                  box_kind,
  input  logic                        wants_notify,
  input  logic                        cfg_we,
  input  logic [apct_pkg::MASK_W-1:0] cfg_wdata,
  output logic                        reply_valid,
  output logic [2:0]                  reply_kind,
  output logic [2:0]                  owner_slot,
  output logic [2:0]                  other_slot,
  output logic                        last
);
  import apct_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  apct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  apct_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .slot_sel     (slot_sel),
    .box_x        (box_x),
    .box_y        (box_y),
    .box_w        (box_w),
    .box_h        (box_h),
    .box_kind     (box_kind),
    .wants_notify (wants_notify),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .reply_valid  (reply_valid),
    .reply_kind   (reply_kind),
    .owner_slot   (owner_slot),
    .other_slot   (other_slot),
    .last         (last)
  );

endmodule

@@ rtl/core/apct_checker.sv @@
`timescale 1ns / 1ps
module apct_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic [1:0]                  req_type,
  input logic                        reply_valid,
  input logic [2:0]                  reply_kind,
  input logic [2:0]                  other_slot,
  input logic                        last
);
  import apct_pkg::*;

  // no reply straight after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !reply_valid)
    else $error("reply strobe after reset");

  // add, remove and clear requests answer with one final reply next cycle
  a_short_reply: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type != REQ_SCAN) |=> (reply_valid && last && !busy))
    else $error("short request did not reply in one cycle");

  // a scan keeps the block busy
  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == REQ_SCAN) |=> busy)
    else $error("scan accepted but not busy");

  // notices never end a request, done always does
  a_notice_last: assert property (@(posedge clk) disable iff (rst)
    (reply_valid && reply_kind == RK_NOTICE) |-> !last)
    else $error("notice flagged last");

  a_other_zero: assert property (@(posedge clk) disable iff (rst)
    (reply_valid && reply_kind != RK_NOTICE) |-> (other_slot == 3'd0 && last))
    else $error("non-notice reply malformed");

endmodule

bind aabb_pair_collision_table_top apct_checker u_apct_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .req_type    (req_type),
  .reply_valid (reply_valid),
  .reply_kind  (reply_kind),
  .other_slot  (other_slot),
  .last        (last)
);
